FILE: rtl/assert_macros.svh
// Assertion macros shared by the bookkeeper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition holds on every clock edge outside reset.
`define SISB_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("sisb assertion failed");
// Check that a trigger implies a consequence on the same edge.
`define SISB_ASSERT_IMPL(lbl, clk, rst_n, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
	else $error("sisb implication failed");
`endif

FILE: rtl/sisb_pkg.sv
// Types and constants of the SIS state bookkeeper.
package sisb_pkg;
	localparam int NODES    = 1024;
	localparam int MAX_DEG  = 16;
	localparam int NODE_W   = 10;
	localparam int CNT_W    = 5;
	localparam int SZ_W     = 11;
	localparam int SI_W     = 15;
	localparam int BKT_N    = MAX_DEG + 1;
	localparam int SLOT_W   = 4;
	localparam int ADJ_AW   = NODE_W + SLOT_W;
	localparam int BM_AW    = CNT_W + NODE_W;
	localparam int BM_DEPTH = BKT_N * NODES;
	localparam int SI_MAX   = NODES * MAX_DEG;

	typedef logic [2:0] req_type_t;
	localparam req_type_t REQ_FLIP     = 3'd0;
	localparam req_type_t REQ_RD_INF   = 3'd1;
	localparam req_type_t REQ_RD_BKT   = 3'd2;
	localparam req_type_t REQ_LOAD_ADJ = 3'd3;
	localparam req_type_t REQ_LOAD_DEG = 3'd4;

	typedef struct packed {
		req_type_t   req_type;
		logic [9:0]  node_id;
		logic [9:0]  slot;
		logic [4:0]  bucket;
		logic [9:0]  load_value;
	} req_t;

	typedef struct packed {
		logic [9:0]  member_node;
		logic [10:0] infected_total;
		logic [14:0] si_links;
		logic [10:0] bucket_count;
		logic        status;
	} res_t;
endpackage

FILE: rtl/sis_network_state_bookkeeper.sv
// Top level of the SIS network state bookkeeper: stream ports and result register.
// After reset the block clears node state and bucket zero and takes no
// request until that is done. The next request is taken only once the last
// result has left the sequencer. A flip walks every neighbor of the node (up
// to 16) one after another, since every neighbor's count and bucket move
// goes through the single read port of each state memory. Results wait in
// an output register.
module sis_network_state_bookkeeper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // node_id, slot, bucket, load_value, zero pad
	input  logic [2:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // member_node, infected_total, si_links, bucket_count, status
);
	import sisb_pkg::*;

	req_t req;
	res_t res, res_q;
	logic res_valid, res_ready, out_q;

	// Unpack the request
	always_comb begin
		req.req_type   = s_tuser;
		req.node_id    = s_tdata[9:0];
		req.slot       = s_tdata[19:10];
		req.bucket     = s_tdata[24:20];
		req.load_value = s_tdata[34:25];
	end

	sisb_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.req_valid(s_tvalid), .req_ready(s_tready), .req(req),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	// Hold the result until taken
	assign res_ready = !out_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= 1'b0;
		end else if (res_ready) begin
			out_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) res_q <= res;
	end

	assign m_tvalid = out_q;
	assign m_tdata  = {res_q.status, res_q.bucket_count, res_q.si_links,
		res_q.infected_total, res_q.member_node};
endmodule

FILE: rtl/sisb_engine.sv
// Sequencer and state memories of the SIS bookkeeper.
`include "assert_macros.svh"
module sisb_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sisb_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output sisb_pkg::res_t res
);
	import sisb_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DISP, S_RD_WAIT, S_F_DEC, S_BTAKE2, S_IPUT, S_ITAKE2,
		S_BPUT, S_W_ADDR, S_W_NODE, S_W_DEC, S_FIN
	} state_t;

	state_t state_q;
	req_t   req_q;
	logic [NODE_W-1:0] clr_q, v_q, p_q;
	logic [CNT_W-1:0]  ct_q, cp_q, deg_q, j_q;
	logic              up_q, walk_q;
	logic [NODE_W-1:0] member_q;
	logic              status_q;
	logic [SZ_W-1:0]   icnt_q;
	logic [SI_W-1:0]   si_q;
	logic [SZ_W-1:0]   bsize_q [0:BKT_N-1];

	// State memories
	logic              mark_mem [0:NODES-1];
	logic [CNT_W-1:0]  cnt_mem  [0:NODES-1];
	logic [NODE_W-1:0] pos_mem  [0:NODES-1];
	logic [CNT_W-1:0]  deg_mem  [0:NODES-1];
	logic [NODE_W-1:0] adj_mem  [0:(1<<ADJ_AW)-1];
	logic [NODE_W-1:0] bm_mem   [0:BM_DEPTH-1];
	logic [NODE_W-1:0] im_mem   [0:NODES-1];

	logic              mark_rd, mark_we, mark_wd;
	logic [CNT_W-1:0]  cnt_rd, cnt_wd, deg_rd, deg_wd;
	logic              cnt_we, deg_we, pos_we, adj_we, bm_we, im_we;
	logic [NODE_W-1:0] pos_rd, pos_wd, adj_rd, adj_wd, bm_rd, bm_wd, im_rd, im_wd;
	logic [NODE_W-1:0] node_ra, mark_wa, cnt_wa, pos_wa, deg_wa, im_wa, im_ra;
	logic [ADJ_AW-1:0] adj_wa, adj_ra;
	logic [BM_AW-1:0]  bm_wa, bm_ra;

	// Shared decisions
	logic [CNT_W-1:0]  tk_bkt, nc;
	logic [SZ_W-1:0]   tk_sz, put_sz;
	logic              tk_ok, itk_ok, put_ok, skip;
	logic [SZ_W-1:0]   tk_last, icnt_last;

	always_comb begin
		tk_bkt    = cnt_rd;
		tk_sz     = bsize_q[tk_bkt];
		tk_ok     = (tk_sz != '0) && ({1'b0, pos_rd} < tk_sz);
		tk_last   = tk_sz - SZ_W'(1);
		itk_ok    = (icnt_q != '0) && ({1'b0, pos_rd} < icnt_q);
		icnt_last = icnt_q - SZ_W'(1);
		put_sz    = bsize_q[cp_q];
		put_ok    = put_sz < SZ_W'(NODES);
		skip      = up_q ? (cnt_rd >= CNT_W'(MAX_DEG)) : (cnt_rd == '0);
		nc        = up_q ? cnt_rd + CNT_W'(1) : cnt_rd - CNT_W'(1);
	end

	// Drive memory ports from the sequencer state
	always_comb begin
		mark_we = 1'b0; mark_wa = req_q.node_id; mark_wd = 1'b0;
		cnt_we  = 1'b0; cnt_wa  = v_q; cnt_wd = nc;
		pos_we  = 1'b0; pos_wa  = v_q; pos_wd = p_q;
		deg_we  = 1'b0; deg_wa  = req_q.node_id;
		deg_wd  = (req_q.load_value > NODE_W'(MAX_DEG)) ? CNT_W'(MAX_DEG)
			: req_q.load_value[CNT_W-1:0];
		adj_we  = 1'b0; adj_wa = {req_q.node_id, req_q.slot[SLOT_W-1:0]};
		adj_wd  = req_q.load_value;
		bm_we   = 1'b0; bm_wa = {ct_q, p_q}; bm_wd = bm_rd;
		im_we   = 1'b0; im_wa = p_q; im_wd = im_rd;
		node_ra = req_q.node_id;
		adj_ra  = {req_q.node_id, j_q[SLOT_W-1:0]};
		bm_ra   = {req_q.bucket, req_q.slot};
		im_ra   = req_q.slot;
		case (state_q)
			S_CLR: begin
				mark_we = 1'b1; mark_wa = clr_q;
				cnt_we  = 1'b1; cnt_wa = clr_q; cnt_wd = '0;
				pos_we  = 1'b1; pos_wa = clr_q; pos_wd = clr_q;
				bm_we   = 1'b1; bm_wa = {CNT_W'(0), clr_q}; bm_wd = clr_q;
			end
			S_DISP: begin
				adj_we = (req_q.req_type == REQ_LOAD_ADJ) && (req_q.slot < NODE_W'(MAX_DEG));
				deg_we = (req_q.req_type == REQ_LOAD_DEG);
			end
			S_F_DEC: begin
				mark_we = 1'b1; mark_wd = ~mark_rd;
				bm_ra   = {cnt_rd, tk_last[NODE_W-1:0]};
				im_ra   = icnt_last[NODE_W-1:0];
			end
			S_BTAKE2: begin
				bm_we  = 1'b1;
				pos_we = 1'b1; pos_wa = bm_rd; pos_wd = p_q;
			end
			S_IPUT: begin
				im_we  = icnt_q < SZ_W'(NODES);
				im_wa  = icnt_q[NODE_W-1:0]; im_wd = v_q;
				pos_we = im_we; pos_wd = icnt_q[NODE_W-1:0];
			end
			S_ITAKE2: begin
				im_we  = 1'b1;
				pos_we = 1'b1; pos_wa = im_rd; pos_wd = p_q;
			end
			S_BPUT: begin
				bm_we  = put_ok; bm_wa = {cp_q, put_sz[NODE_W-1:0]}; bm_wd = v_q;
				pos_we = put_ok; pos_wd = put_sz[NODE_W-1:0];
			end
			S_W_NODE: begin
				node_ra = adj_rd;
			end
			S_W_DEC: begin
				cnt_we = ~skip;
				bm_ra  = {cnt_rd, tk_last[NODE_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	// Memory arrays with registered reads
	always_ff @(posedge clk) begin
		if (mark_we) mark_mem[mark_wa] <= mark_wd;
		if (cnt_we)  cnt_mem[cnt_wa]   <= cnt_wd;
		if (pos_we)  pos_mem[pos_wa]   <= pos_wd;
		if (deg_we)  deg_mem[deg_wa]   <= deg_wd;
		if (adj_we)  adj_mem[adj_wa]   <= adj_wd;
		if (bm_we)   bm_mem[bm_wa]     <= bm_wd;
		if (im_we)   im_mem[im_wa]     <= im_wd;
		mark_rd <= mark_mem[node_ra];
		cnt_rd  <= cnt_mem[node_ra];
		pos_rd  <= pos_mem[node_ra];
		deg_rd  <= deg_mem[node_ra];
		adj_rd  <= adj_mem[adj_ra];
		bm_rd   <= bm_mem[bm_ra];
		im_rd   <= im_mem[im_ra];
	end

	// Request payload
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) req_q <= req;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			icnt_q  <= '0;
			si_q    <= '0;
			for (int b = 0; b < BKT_N; b++) bsize_q[b] <= (b == 0) ? SZ_W'(NODES) : '0;
			v_q <= '0; p_q <= '0; ct_q <= '0; cp_q <= '0; deg_q <= '0; j_q <= '0;
			up_q <= 1'b0; walk_q <= 1'b0; member_q <= '0; status_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == NODE_W'(NODES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) state_q <= S_DISP;
				end
				S_DISP: begin
					member_q <= '0;
					case (req_q.req_type)
						REQ_FLIP: begin
							status_q <= 1'b0;
							state_q  <= S_F_DEC;
						end
						REQ_RD_INF: begin
							if ({1'b0, req_q.slot} < icnt_q) begin
								status_q <= 1'b0;
								state_q  <= S_RD_WAIT;
							end else begin
								status_q <= 1'b1;
								state_q  <= S_FIN;
							end
						end
						REQ_RD_BKT: begin
							if (req_q.bucket <= CNT_W'(MAX_DEG)
								&& {1'b0, req_q.slot} < bsize_q[req_q.bucket]) begin
								status_q <= 1'b0;
								state_q  <= S_RD_WAIT;
							end else begin
								status_q <= 1'b1;
								state_q  <= S_FIN;
							end
						end
						REQ_LOAD_ADJ: begin
							status_q <= (req_q.slot >= NODE_W'(MAX_DEG));
							state_q  <= S_FIN;
						end
						REQ_LOAD_DEG: begin
							status_q <= 1'b0;
							state_q  <= S_FIN;
						end
						default: begin
							status_q <= 1'b1;
							state_q  <= S_FIN;
						end
					endcase
				end
				S_RD_WAIT: begin
					member_q <= (req_q.req_type == REQ_RD_INF) ? im_rd : bm_rd;
					state_q  <= S_FIN;
				end
				S_F_DEC: begin
					v_q    <= req_q.node_id;
					p_q    <= pos_rd;
					ct_q   <= cnt_rd;
					cp_q   <= cnt_rd;
					deg_q  <= deg_rd;
					j_q    <= '0;
					walk_q <= 1'b0;
					up_q   <= ~mark_rd;
					if (!mark_rd) state_q <= tk_ok ? S_BTAKE2 : S_IPUT;
					else state_q <= itk_ok ? S_ITAKE2 : S_BPUT;
				end
				S_BTAKE2: begin
					bsize_q[ct_q] <= bsize_q[ct_q] - SZ_W'(1);
					si_q          <= si_q - SI_W'(ct_q);
					state_q       <= walk_q ? S_BPUT : S_IPUT;
				end
				S_IPUT: begin
					if (icnt_q < SZ_W'(NODES)) icnt_q <= icnt_q + SZ_W'(1);
					state_q <= S_W_ADDR;
				end
				S_ITAKE2: begin
					icnt_q  <= icnt_q - SZ_W'(1);
					state_q <= S_BPUT;
				end
				S_BPUT: begin
					if (put_ok) begin
						bsize_q[cp_q] <= put_sz + SZ_W'(1);
						si_q          <= si_q + SI_W'(cp_q);
					end
					state_q <= S_W_ADDR;
				end
				S_W_ADDR: begin
					state_q <= (j_q == deg_q) ? S_FIN : S_W_NODE;
				end
				S_W_NODE: begin
					v_q     <= adj_rd;
					state_q <= S_W_DEC;
				end
				S_W_DEC: begin
					j_q     <= j_q + CNT_W'(1);
					ct_q    <= cnt_rd;
					cp_q    <= nc;
					p_q     <= pos_rd;
					walk_q  <= 1'b1;
					state_q <= (!skip && !mark_rd) ? (tk_ok ? S_BTAKE2 : S_BPUT) : S_W_ADDR;
				end
				S_FIN: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);

	// Result assembly
	always_comb begin
		res.member_node    = member_q;
		res.infected_total = icnt_q;
		res.si_links       = si_q;
		res.bucket_count   = (req_q.bucket <= CNT_W'(MAX_DEG)) ? bsize_q[req_q.bucket] : '0;
		res.status         = status_q;
	end

	`SISB_ASSERT_IMPL(a_clr_blocks, clk, arst_n, state_q == S_CLR, !req_ready)
	`SISB_ASSERT_ALWAYS(a_icnt_range, clk, arst_n, icnt_q <= SZ_W'(NODES))
	`SISB_ASSERT_ALWAYS(a_si_range, clk, arst_n, si_q <= SI_W'(SI_MAX))
	`SISB_ASSERT_IMPL(a_walk_bound, clk, arst_n, state_q == S_W_NODE, j_q < deg_q)
endmodule

FILE: bench/testbench.sv
// Self-checking bench for the SIS network state bookkeeper: graph load, flips and reads.
`timescale 1ns / 1ps

module testbench;
	import sisb_pkg::*;

	localparam req_type_t REQ_BAD_5 = 3'd5;
	localparam req_type_t REQ_BAD_7 = 3'd7;
	localparam int ACTIVE_N = 20;

	typedef struct {
		req_t r;
		bit   typed;
		res_t want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	sis_network_state_bookkeeper uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Mirror of the block state
	bit mark_q [NODES];
	int nbr_inf [NODES];
	int pos_q [NODES];
	int deg_q [NODES];
	int adj_q [NODES*MAX_DEG];
	int bkt_mem [BM_DEPTH];
	int bkt_len [BKT_N];
	int inf_mem [NODES];
	int inf_len;
	int si_sum;

	res_t pending_results [$];
	int   errors = 0;
	int   phase = 0;
	bit   hold_go = 0;
	int   hold_left = 0;
	row_t rows [$];

	// Graph used by the random part
	int act [ACTIVE_N];
	int nb [ACTIVE_N][$];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic clear_state();
		for (int i = 0; i < NODES; i++) begin
			mark_q[i] = 0; nbr_inf[i] = 0; pos_q[i] = i; deg_q[i] = 0; bkt_mem[i] = i;
		end
		for (int b = 0; b < BKT_N; b++) bkt_len[b] = 0;
		bkt_len[0] = NODES;
		inf_len = 0;
		si_sum = 0;
	endtask

	function automatic void bkt_remove(int v, int m);
		int sz;
		int p;
		int mv;
		sz = bkt_len[m];
		p = pos_q[v];
		if (sz == 0 || p >= sz) return;
		mv = bkt_mem[m*NODES + sz - 1];
		bkt_mem[m*NODES + p] = mv;
		pos_q[mv] = p;
		bkt_len[m] = sz - 1;
		si_sum -= m;
	endfunction

	function automatic void bkt_insert(int v, int m);
		int sz;
		sz = bkt_len[m];
		if (sz >= NODES) return;
		bkt_mem[m*NODES + sz] = v;
		pos_q[v] = sz;
		bkt_len[m] = sz + 1;
		si_sum += m;
	endfunction

	// Move each neighbor of n one count up or down, re-bucketing susceptible ones
	function automatic void shift_neighbors(int n, bit up);
		int k;
		int v;
		int c;
		int nc;
		k = deg_q[n] > MAX_DEG ? MAX_DEG : deg_q[n];
		for (int j = 0; j < k; j++) begin
			v = adj_q[n*MAX_DEG + j];
			c = nbr_inf[v];
			if (up && c >= MAX_DEG) continue;
			if (!up && c == 0) continue;
			nc = up ? c + 1 : c - 1;
			if (!mark_q[v]) bkt_remove(v, c);
			nbr_inf[v] = nc;
			if (!mark_q[v]) bkt_insert(v, nc);
		end
	endfunction

	// Apply one request to the mirror and return the result it gives
	function automatic res_t apply_request(req_t r);
		res_t o;
		int n;
		int s;
		int b;
		int p;
		int mv;
		n = r.node_id; s = r.slot; b = r.bucket;
		o = '0;
		case (r.req_type)
			REQ_FLIP: begin
				if (!mark_q[n]) begin
					bkt_remove(n, nbr_inf[n]);
					mark_q[n] = 1;
					if (inf_len < NODES) begin
						inf_mem[inf_len] = n; pos_q[n] = inf_len; inf_len++;
					end
					shift_neighbors(n, 1);
				end else begin
					p = pos_q[n];
					if (inf_len != 0 && p < inf_len) begin
						mv = inf_mem[inf_len-1];
						inf_mem[p] = mv; pos_q[mv] = p; inf_len--;
					end
					mark_q[n] = 0;
					bkt_insert(n, nbr_inf[n]);
					shift_neighbors(n, 0);
				end
			end
			REQ_RD_INF: begin
				if (s < inf_len) o.member_node = NODE_W'(inf_mem[s]);
				else o.status = 1;
			end
			REQ_RD_BKT: begin
				if (b <= MAX_DEG && s < bkt_len[b]) o.member_node = NODE_W'(bkt_mem[b*NODES + s]);
				else o.status = 1;
			end
			REQ_LOAD_ADJ: begin
				if (s >= MAX_DEG) o.status = 1;
				else adj_q[n*MAX_DEG + s] = r.load_value;
			end
			REQ_LOAD_DEG: deg_q[n] = r.load_value > MAX_DEG ? MAX_DEG : r.load_value;
			default: o.status = 1;
		endcase
		o.infected_total = SZ_W'(inf_len);
		o.si_links = SI_W'(si_sum);
		o.bucket_count = SZ_W'(b <= MAX_DEG ? bkt_len[b] : 0);
		return o;
	endfunction

	// Offer one request, wait for acceptance, then idle per phase
	task automatic offer(req_t r, bit typed, res_t want);
		res_t got;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, r.load_value, r.bucket, r.slot, r.node_id};
		s_tuser  <= r.req_type;
		do @(posedge clk); while (!s_tready);
		got = apply_request(r);
		pending_results.insert(pending_results.size(), typed ? want : got);
		if ((phase == 1 || phase == 3) && $urandom_range(99) < (phase == 1 ? 83 : 6)) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < (phase == 1 ? 83 : 6));
		end
	endtask

	task automatic add_row(req_type_t t, int n, int s, int b, int v, bit typed,
			int mem, int inf, int si, int bc, bit st);
		row_t w;
		w.r = '{req_type: t, node_id: NODE_W'(n), slot: NODE_W'(s), bucket: CNT_W'(b),
			load_value: NODE_W'(v)};
		w.typed = typed;
		w.want = '{member_node: NODE_W'(mem), infected_total: SZ_W'(inf),
			si_links: SI_W'(si), bucket_count: SZ_W'(bc), status: st};
		rows.insert(rows.size(), w);
	endtask

	function automatic req_t mk(req_type_t t, int n, int s, int b, int v);
		req_t r;
		r = '{req_type: t, node_id: NODE_W'(n), slot: NODE_W'(s), bucket: CNT_W'(b),
			load_value: NODE_W'(v)};
		return r;
	endfunction

	// Receiver: random stall per phase, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_go) begin
			hold_go = 0;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !((phase == 2 && $urandom_range(99) < 83) ||
				(phase == 3 && $urandom_range(99) < 6));
		end
	end

	// Compare each delivered result with the oldest expectation
	always @(posedge clk) begin
		res_t act_res;
		res_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			act_res = '{member_node: m_tdata[9:0], infected_total: m_tdata[20:10],
				si_links: m_tdata[35:21], bucket_count: m_tdata[46:36],
				status: m_tdata[47]};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (act_res.member_node !== exp_res.member_node ||
						act_res.infected_total !== exp_res.infected_total ||
						act_res.si_links !== exp_res.si_links ||
						act_res.bucket_count !== exp_res.bucket_count ||
						act_res.status !== exp_res.status) begin
					$display("%0t: mismatch expected mem=%0d inf=%0d si=%0d bc=%0d st=%0d",
						$time, exp_res.member_node, exp_res.infected_total,
						exp_res.si_links, exp_res.bucket_count, exp_res.status);
					$display("%0t:          actual   mem=%0d inf=%0d si=%0d bc=%0d st=%0d",
						$time, act_res.member_node, act_res.infected_total,
						act_res.si_links, act_res.bucket_count, act_res.status);
					errors++;
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("** sis_network_state_bookkeeper: FAILED **");
		$finish;
	end

	initial begin
		req_t r;
		int i;
		int j;
		int k;
		int x;
		bit dup;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		arst_n = 1'b0;
		clear_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset contents, bad requests, saturation, degree-zero flips
		add_row(REQ_RD_INF,   0, 0,    0,  0,    1, 0,    0, 0, 1024, 1);
		add_row(REQ_RD_BKT,   0, 1023, 0,  0,    1, 1023, 0, 0, 1024, 0);
		add_row(REQ_RD_BKT,   0, 0,    16, 0,    1, 0,    0, 0, 0,    1);
		add_row(REQ_RD_BKT,   0, 0,    31, 0,    1, 0,    0, 0, 0,    1);
		add_row(REQ_BAD_5,    7, 3,    0,  9,    1, 0,    0, 0, 1024, 1);
		add_row(REQ_BAD_7, 1023, 1023, 31, 1023, 1, 0,    0, 0, 0,    1);
		add_row(REQ_LOAD_ADJ, 5, 16,   0,  3,    1, 0,    0, 0, 1024, 1);
		add_row(REQ_LOAD_ADJ, 5, 1023, 0,  1023, 1, 0,    0, 0, 1024, 1);
		add_row(REQ_LOAD_DEG, 1023, 0, 0,  1023, 1, 0,    0, 0, 1024, 0);
		add_row(REQ_LOAD_DEG, 0, 0,    0,  0,    1, 0,    0, 0, 1024, 0);
		add_row(REQ_FLIP,     0, 0,    0,  0,    1, 0,    1, 0, 1023, 0);
		add_row(REQ_RD_INF,   0, 0,    0,  0,    1, 0,    1, 0, 1023, 0);
		add_row(REQ_RD_BKT,   0, 0,    0,  0,    1, 1023, 1, 0, 1023, 0);
		add_row(REQ_FLIP,     0, 0,    0,  0,    1, 0,    0, 0, 1024, 0);
		add_row(REQ_RD_BKT,   0, 1023, 0,  0,    1, 0,    0, 0, 1024, 0);
		foreach (rows[i]) offer(rows[i].r, rows[i].typed, rows[i].want);

		// Build a small random graph; the highest node is a full-degree hub
		act[0] = 0;
		act[1] = 1023;
		for (i = 2; i < ACTIVE_N; i++) begin
			do begin
				x = $urandom_range(1, 1022);
				dup = 0;
				for (j = 1; j < i; j++) if (act[j] == x) dup = 1;
			end while (dup);
			act[i] = x;
		end
		for (i = 2; i < 18; i++) begin
			nb[1].insert(nb[1].size(), i);
			nb[i].insert(nb[i].size(), 1);
		end
		for (k = 0; k < 90; k++) begin
			i = $urandom_range(ACTIVE_N-1);
			j = $urandom_range(ACTIVE_N-1);
			dup = (i == j) || nb[i].size() >= MAX_DEG || nb[j].size() >= MAX_DEG;
			for (int e = 0; e < nb[i].size(); e++) if (nb[i][e] == j) dup = 1;
			if (!dup) begin
				nb[i].insert(nb[i].size(), j);
				nb[j].insert(nb[j].size(), i);
			end
		end
		// Load degrees and all adjacency slots of the active nodes
		for (i = 0; i < ACTIVE_N; i++) begin
			k = nb[i].size();
			offer(mk(REQ_LOAD_DEG, act[i], $urandom_range(1023), $urandom_range(31),
				k == MAX_DEG ? $urandom_range(MAX_DEG, 1023) : k), 0, '0);
			for (j = 0; j < MAX_DEG; j++)
				offer(mk(REQ_LOAD_ADJ, act[i], j, $urandom_range(31),
					j < k ? act[nb[i][j]] : act[$urandom_range(ACTIVE_N-1)]), 0, '0);
		end

		// Random traffic in four phases, idling the sender or receiver in some of them
		for (phase = 0; phase < 4; phase++) begin
			if (phase == 2) hold_go = 1;
			for (k = 0; k < 160; k++) begin
				x = $urandom_range(99);
				i = $urandom_range(ACTIVE_N-1);
				if (x < 45) begin
					r = mk(REQ_FLIP, act[i], $urandom_range(1023), $urandom_range(17),
						$urandom_range(1023));
				end else if (x < 70) begin
					j = $urandom_range(5) == 0 ? $urandom_range(31) : $urandom_range(4);
					r = mk(REQ_RD_BKT, $urandom_range(1023),
						j <= MAX_DEG && bkt_len[j] > 0 && $urandom_range(3) != 0 ?
						$urandom_range(bkt_len[j]-1) : $urandom_range(1023), j,
						$urandom_range(1023));
				end else if (x < 85) begin
					r = mk(REQ_RD_INF, $urandom_range(1023),
						inf_len > 0 && $urandom_range(3) != 0 ?
						$urandom_range(inf_len-1) : $urandom_range(inf_len, 1023),
						$urandom_range(31), $urandom_range(1023));
				end else if (x < 90) begin
					r = mk(REQ_LOAD_ADJ, act[i], $urandom_range(MAX_DEG-1), $urandom_range(31),
						act[$urandom_range(ACTIVE_N-1)]);
				end else if (x < 93) begin
					r = mk(REQ_LOAD_DEG, act[i], $urandom_range(1023), $urandom_range(31),
						$urandom_range(1023));
				end else if (x < 97) begin
					r = mk(REQ_LOAD_ADJ, $urandom_range(1023), $urandom_range(MAX_DEG, 1023),
						$urandom_range(31), $urandom_range(1023));
				end else begin
					r = mk(req_type_t'($urandom_range(REQ_BAD_5, REQ_BAD_7)),
						$urandom_range(1023), $urandom_range(1023), $urandom_range(31),
						$urandom_range(1023));
				end
				offer(r, 0, '0);
			end
		end
		s_tvalid <= 1'b0;
		phase = 0;

		// Drain, then let the block settle
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("** sis_network_state_bookkeeper: PASSED **");
		else
			$display("** sis_network_state_bookkeeper: FAILED **");
		$finish;
	end
endmodule

FILE: sis_network_state_bookkeeper.f
+incdir+rtl
rtl/sisb_pkg.sv
rtl/sisb_engine.sv
rtl/sis_network_state_bookkeeper.sv
bench/testbench.sv
